FILE: hw/rtl/tdbh_pkg.sv
package tdbh_pkg;

  // Field and word widths
  localparam int BYTE_W = 8;
  localparam int HALF_W = 16;
  localparam int WORD_W = 32;

  // TEA cipher constants
  localparam int TEA_ROUNDS = 32;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Round counter width, kept at least one bit wide
  localparam int RND_W = (TEA_ROUNDS > 1) ? $clog2(TEA_ROUNDS) : 1;

endpackage

FILE: hw/rtl/tdbh_if.sv
interface tdbh_in_if
  import tdbh_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [BYTE_W-1:0] text_byte;
  logic                     end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tdbh_out_if
  import tdbh_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] h_word_one;
  logic [WORD_W-1:0] h_word_two;
  logic [WORD_W-1:0] g_word_one;
  logic [WORD_W-1:0] g_word_two;

  modport source (output valid, output h_word_one, output h_word_two,
                  output g_word_one, output g_word_two, input ready);
  modport sink   (input valid, input h_word_one, input h_word_two,
                  input g_word_one, input g_word_two, output ready);
endinterface

FILE: hw/rtl/tea_double_block_hash_top.sv
// TEA double-block hash. Text enters one signed byte per beat on text_in, the
// last byte of a string flagged by end_of_text; after that byte the four
// chaining words (h1, h2, g1, g2) leave as one beat on hash_out and the chain
// returns to zero for the next string. Each byte is first accepted from idle,
// then worked by two dependent TEA passes on a single shared round unit, one
// full round per cycle except while a final byte stalls in its last round. text_in is
// not ready while a byte is being worked. The finished hash sits in an output
// register, so the next string may start while it waits; a final byte that
// completes while an older hash is still untaken holds in its last round until
// hash_out frees. No clearing pass is needed after reset.
module tea_double_block_hash_top
  import tdbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tdbh_in_if.sink           text_in,
  tdbh_out_if.source        hash_out
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2
  } state_t;

  state_t            state;
  logic [RND_W-1:0]  round_cnt;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] z;
  logic [WORD_W-1:0] r1;
  logic [WORD_W-1:0] r2;
  logic [WORD_W-1:0] h1;
  logic [WORD_W-1:0] h2;
  logic [WORD_W-1:0] g1;
  logic [WORD_W-1:0] g2;
  logic [BYTE_W-1:0] byte_q;
  logic              eot_q;
  logic              out_valid;

  logic [WORD_W-1:0] ext;
  logic [WORD_W-1:0] key_hi;
  logic [WORD_W-1:0] key_lo;
  logic [WORD_W-1:0] k0, k1, k2, k3;
  logic [WORD_W-1:0] y_new;
  logic [WORD_W-1:0] z_new;
  logic              last_round;
  logic              stall;
  logic              in_beat;
  logic              emit;

  // Byte sign-extension and half-word key words
  assign ext    = {{(WORD_W-BYTE_W){byte_q[BYTE_W-1]}}, byte_q};
  assign key_hi = {{(WORD_W-HALF_W){1'b0}}, ext[WORD_W-1:HALF_W]};
  assign key_lo = {{(WORD_W-HALF_W){1'b0}}, ext[HALF_W-1:0]};

  // Key select per pass
  always_comb begin
    if (state == ST_PASS2) begin
      k0 = key_hi;
      k1 = key_lo;
      k2 = r1;
      k3 = r2;
    end else begin
      k0 = g1;
      k1 = g2;
      k2 = key_hi;
      k3 = key_lo;
    end
  end

  // Shared TEA round unit
  always_comb begin
    y_new = y + (((z << 4) + k0) ^ (z + sum) ^ ((z >> 5) + k1));
    z_new = z + (((y_new << 4) + k2) ^ (y_new + sum) ^ ((y_new >> 5) + k3));
  end

  assign last_round = (round_cnt == RND_W'(TEA_ROUNDS - 1));
  // Final hash cannot land while an older one is still untaken
  assign stall      = eot_q && out_valid && !hash_out.ready;
  assign in_beat    = text_in.valid && text_in.ready;
  // Final byte finishing its second pass loads the output register
  assign emit       = (state == ST_PASS2) && last_round && eot_q && !stall;

  assign text_in.ready       = (state == ST_IDLE);
  assign hash_out.valid      = out_valid;

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
      out_valid <= 1'b0;
      h1        <= '0;
      h2        <= '0;
      g1        <= '0;
      g2        <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (hash_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            byte_q    <= text_in.text_byte;
            eot_q     <= text_in.end_of_text;
            y         <= h1;
            z         <= h2;
            sum       <= TEA_DELTA;
            round_cnt <= '0;
            state     <= ST_PASS1;
          end
        end
        ST_PASS1: begin
          if (last_round) begin
            h1        <= h1 ^ y_new;
            h2        <= h2 ^ z_new;
            r1        <= y_new;
            r2        <= z_new;
            y         <= g1;
            z         <= g2;
            sum       <= TEA_DELTA;
            round_cnt <= '0;
            state     <= ST_PASS2;
          end else begin
            y         <= y_new;
            z         <= z_new;
            sum       <= sum + TEA_DELTA;
            round_cnt <= round_cnt + 1'b1;
          end
        end
        ST_PASS2: begin
          if (last_round) begin
            if (!stall) begin
              round_cnt <= '0;
              state     <= ST_IDLE;
              if (eot_q) begin
                hash_out.h_word_one <= h1;
                hash_out.h_word_two <= h2;
                hash_out.g_word_one <= g1 ^ y_new;
                hash_out.g_word_two <= g2 ^ z_new;
                h1 <= '0;
                h2 <= '0;
                g1 <= '0;
                g2 <= '0;
              end else begin
                g1 <= g1 ^ y_new;
                g2 <= g2 ^ z_new;
              end
            end
          end else begin
            y         <= y_new;
            z         <= z_new;
            sum       <= sum + TEA_DELTA;
            round_cnt <= round_cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A byte beat starts a pass, and the port stays closed while it runs
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_PASS1) && !text_in.ready)
    else $error("text_in ready right after a byte beat");

  // Counter rests at zero between bytes
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (round_cnt == '0))
    else $error("round counter not cleared in idle");

  // A new hash appears only with the chain cleared for the next string
  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_out.valid) |-> (h1 == '0) && (h2 == '0) && (g1 == '0) && (g2 == '0))
    else $error("chain not cleared when hash emitted");

  // Pass two always follows pass one after its last round
  a_pass_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS1) && last_round |=> (state == ST_PASS2) && (round_cnt == '0))
    else $error("second pass did not follow first");

  // Stalled final byte holds its results
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS2) && last_round && stall |=> (state == ST_PASS2) && $stable(y) && $stable(z))
    else $error("stalled final round moved on");

endmodule

FILE: test/tdbh_hash_checker.sv
module tdbh_hash_checker
  import tdbh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tdbh_in_if   text_in,
  tdbh_out_if  hash_out,
  output int   mismatch_count,
  output int   hashes_pending
);

  localparam int REPORT_LIMIT = 10;

  // word slots of one hash, slot 0 is the low end of the packed vector
  localparam int H_ONE = 0;
  localparam int H_TWO = 1;
  localparam int G_ONE = 2;
  localparam int G_TWO = 3;

  typedef logic [3:0][WORD_W-1:0] hash_words_t;

  hash_words_t chain_state;
  hash_words_t expected_hashes [$];
  string       word_name [4] = '{"h_word_one", "h_word_two", "g_word_one", "g_word_two"};

  // one full TEA encryption of (y, z) under key (k0..k3)
  function automatic void tea_encrypt(input logic [WORD_W-1:0] k0, k1, k2, k3,
                                      inout logic [WORD_W-1:0] y, z);
    logic [WORD_W-1:0] sum;
    sum = '0;
    for (int r = 0; r < TEA_ROUNDS; r++) begin
      sum = sum + TEA_DELTA;
      y   = y + (((z << 4) + k0) ^ (z + sum) ^ ((z >> 5) + k1));
      z   = z + (((y << 4) + k2) ^ (y + sum) ^ ((y >> 5) + k3));
    end
  endfunction

  // chain update for one text byte
  function automatic hash_words_t absorb_byte(hash_words_t cur, logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] ext, hi, lo, r1, r2, q1, q2;
    hash_words_t       nxt;
    ext = {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
    hi  = {{(WORD_W-HALF_W){1'b0}}, ext[WORD_W-1:HALF_W]};
    lo  = {{(WORD_W-HALF_W){1'b0}}, ext[HALF_W-1:0]};
    r1  = cur[H_ONE];
    r2  = cur[H_TWO];
    q1  = cur[G_ONE];
    q2  = cur[G_TWO];
    tea_encrypt(cur[G_ONE], cur[G_TWO], hi, lo, r1, r2);
    // g pass is keyed by the fresh h pass output
    tea_encrypt(hi, lo, r1, r2, q1, q2);
    nxt[H_ONE] = cur[H_ONE] ^ r1;
    nxt[H_TWO] = cur[H_TWO] ^ r2;
    nxt[G_ONE] = cur[G_ONE] ^ q1;
    nxt[G_TWO] = cur[G_TWO] ^ q2;
    return nxt;
  endfunction

  // sample both channels at the edge, predict on input beats, compare on output beats
  always @(posedge clk) begin : watch
    hash_words_t got, want;
    logic        bad;
    if (rst) begin
      chain_state = '0;
      expected_hashes.delete();
    end else begin
      if (text_in.valid && text_in.ready) begin
        chain_state = absorb_byte(chain_state, text_in.text_byte);
        if (text_in.end_of_text) begin
          expected_hashes.push_back(chain_state);
          chain_state = '0;
        end
      end
      if (hash_out.valid && hash_out.ready) begin
        got = {hash_out.g_word_two, hash_out.g_word_one,
               hash_out.h_word_two, hash_out.h_word_one};
        if (expected_hashes.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: hash beat with none expected: %h", $realtime, got);
          mismatch_count++;
        end else begin
          want = expected_hashes.pop_front();
          bad  = 1'b0;
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              bad = 1'b1;
              if (mismatch_count < REPORT_LIMIT)
                $display("%0t: %s expected %h got %h", $realtime, word_name[i],
                         want[i], got[i]);
            end
          end
          if (bad)
            mismatch_count++;
        end
      end
    end
    hashes_pending = expected_hashes.size();
  end

endmodule

FILE: test/tb_tea_double_block_hash_top.sv
module tb_tea_double_block_hash_top;
  import tdbh_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 600;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 2 * TEA_ROUNDS + 16;
  localparam int DIRECTED_LEN  = 15;

  typedef enum {RX_STREAM, RX_CHOPPY, RX_BLOCKED} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatch_count;
  int   hashes_pending;
  int   idle_cycles;
  int   burst_left;
  int   bytes_sent;

  // directed text: edge bytes as one-byte strings, a mixed string, then a
  // short ascii string and a repeat to show the chain clears between strings
  logic [BYTE_W-1:0] directed_text [DIRECTED_LEN] = '{
    8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01,
    8'h7F, 8'h80, 8'h00, 8'hFF, 8'h55, 8'hAA,
    8'h48, 8'h69, 8'h21,
    8'h00};
  logic directed_last [DIRECTED_LEN] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b1};

  tdbh_in_if  text_in_bus ();
  tdbh_out_if hash_out_bus ();

  tea_double_block_hash_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in_bus.sink),
    .hash_out (hash_out_bus.source)
  );

  tdbh_hash_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .text_in        (text_in_bus),
    .hash_out       (hash_out_bus),
    .mismatch_count (mismatch_count),
    .hashes_pending (hashes_pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (text_in_bus.valid && text_in_bus.ready) ||
        (hash_out_bus.valid && hash_out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one text beat; bursts of random length with random gaps between them
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        text_in_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    text_in_bus.valid       = 1'b1;
    text_in_bus.text_byte   = b;
    text_in_bus.end_of_text = last;
    @(posedge clk);
    while (!text_in_bus.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // mostly short strings, some medium, a few long
  task automatic send_random_string();
    int len;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14)
      len = $urandom_range(1, 4);
    else if (pick < 18)
      len = $urandom_range(5, 12);
    else
      len = $urandom_range(13, 40);
    for (int i = 0; i < len; i++)
      send_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
  endtask

  // stimulus and verdict
  initial begin
    text_in_bus.valid       = 1'b0;
    text_in_bus.text_byte   = '0;
    text_in_bus.end_of_text = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++)
      send_byte(directed_text[i], directed_last[i]);
    while (bytes_sent < DIRECTED_LEN + RANDOM_ITEMS)
      send_random_string();
    text_in_bus.valid = 1'b0;

    while (hashes_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && hashes_pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // result side stall pattern: stretches of streaming, choppy and mostly blocked
  initial begin
    rx_mode_t mode;
    int       span;
    hash_out_bus.ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_STREAM:  hash_out_bus.ready = 1'b1;
          RX_CHOPPY:  hash_out_bus.ready = 1'($urandom_range(0, 1));
          RX_BLOCKED: hash_out_bus.ready = ($urandom_range(0, 39) == 0);
          default:    hash_out_bus.ready = 1'b1;
        endcase
      end
    end
  end

endmodule
